// File: rtl/sgcr_pkg.sv
// sgcr_pkg: shared widths, types, register indexes and the 5x7 font ROM
// for the scaled glyph cell renderer. No dependencies.
package sgcr_pkg;

  localparam int CODE_W      = 8;
  localparam int COORD_W     = 16;
  localparam int SCALE_W     = 4;
  localparam int COLOR_W     = 32;
  localparam int PITCH_W     = 18;
  localparam int OFFSET_W    = 32;
  localparam int CELL_DIM_W  = 4;
  localparam int CX_W        = COORD_W + 1;
  localparam int PROD_W      = CX_W + PITCH_W;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
  localparam int SLOT_W      = $clog2(GLYPH_CELLS + 1);
  localparam int COL_W       = $clog2(GLYPH_COLS);

  localparam int MAX_SCALE_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PITCH_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_BYTES  = 2'd2;

  typedef logic [GLYPH_CELLS-1:0] glyph_t;
  typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] font_rows_t;

  typedef struct packed {
    logic [COORD_W-1:0] frame_width;
    logic [COORD_W-1:0] frame_height;
    logic [PITCH_W-1:0] pitch_bytes;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [SCALE_W-1:0] scale;
    glyph_t             cells;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_W-1:0]   offset;
    logic [CELL_DIM_W-1:0] width;
    logic [CELL_DIM_W-1:0] height;
    logic [COLOR_W-1:0]    color;
  } res_t;

  function automatic font_rows_t rows7(input int a0, input int a1,
                                       input int a2, input int a3,
                                       input int a4, input int a5,
                                       input int a6);
    return {5'(a6), 5'(a5), 5'(a4), 5'(a3), 5'(a2), 5'(a1), 5'(a0)};
  endfunction

  function automatic font_rows_t font_rows(input logic [CODE_W-1:0] code);
    font_rows_t r;
    r = '0;
    unique case (code)
      8'h30: r = rows7(14, 17, 19, 21, 25, 17, 14);
      8'h31: r = rows7( 4, 12,  4,  4,  4,  4, 14);
      8'h32: r = rows7(14, 17,  1,  2,  4,  8, 31);
      8'h33: r = rows7(30,  1,  1, 14,  1,  1, 30);
      8'h34: r = rows7( 2,  6, 10, 18, 31,  2,  2);
      8'h35: r = rows7(31, 16, 16, 30,  1,  1, 30);
      8'h36: r = rows7(14, 16, 16, 30, 17, 17, 14);
      8'h37: r = rows7(31,  1,  2,  4,  8,  8,  8);
      8'h38: r = rows7(14, 17, 17, 14, 17, 17, 14);
      8'h39: r = rows7(14, 17, 17, 15,  1,  1, 14);
      8'h41: r = rows7(14, 17, 17, 31, 17, 17, 17);
      8'h42: r = rows7(30, 17, 17, 30, 17, 17, 30);
      8'h43: r = rows7(14, 17, 16, 16, 16, 17, 14);
      8'h44: r = rows7(30, 17, 17, 17, 17, 17, 30);
      8'h45: r = rows7(31, 16, 16, 30, 16, 16, 31);
      8'h46: r = rows7(31, 16, 16, 30, 16, 16, 16);
      8'h47: r = rows7(14, 17, 16, 23, 17, 17, 15);
      8'h48: r = rows7(17, 17, 17, 31, 17, 17, 17);
      8'h49: r = rows7(31,  4,  4,  4,  4,  4, 31);
      8'h4B: r = rows7(17, 18, 20, 24, 20, 18, 17);
      8'h4C: r = rows7(16, 16, 16, 16, 16, 16, 31);
      8'h4D: r = rows7(17, 27, 21, 21, 17, 17, 17);
      8'h4E: r = rows7(17, 25, 21, 19, 17, 17, 17);
      8'h4F: r = rows7(14, 17, 17, 17, 17, 17, 14);
      8'h50: r = rows7(30, 17, 17, 30, 16, 16, 16);
      8'h52: r = rows7(30, 17, 17, 30, 20, 18, 17);
      8'h53: r = rows7(15, 16, 16, 14,  1,  1, 30);
      8'h54: r = rows7(31,  4,  4,  4,  4,  4,  4);
      8'h55: r = rows7(17, 17, 17, 17, 17, 17, 14);
      8'h58: r = rows7(17, 17, 10,  4, 10, 17, 17);
      8'h59: r = rows7(17, 17, 10,  4,  4,  4,  4);
      8'h5A: r = rows7(31,  1,  2,  4,  8, 16, 31);
      8'h3A: r = rows7( 0,  4,  4,  0,  4,  4,  0);
      8'h5B: r = rows7(14,  8,  8,  8,  8,  8, 14);
      8'h5D: r = rows7(14,  2,  2,  2,  2,  2, 14);
      8'h2D: r = rows7( 0,  0,  0, 31,  0,  0,  0);
      8'h2E: r = rows7( 0,  0,  0,  0,  0,  6,  6);
      8'h2F: r = rows7( 1,  2,  2,  4,  8,  8, 16);
      8'h28: r = rows7( 2,  4,  8,  8,  8,  4,  2);
      8'h29: r = rows7( 8,  4,  2,  2,  2,  4,  8);
      default: r = '0;
    endcase
    return r;
  endfunction

  // bit k = cell k in scan order (row-major, column bit 4 first)
  function automatic glyph_t scan_order(input font_rows_t rows);
    glyph_t g;
    g = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        g[r*GLYPH_COLS + c] = rows[r][GLYPH_COLS-1-c];
      end
    end
    return g;
  endfunction

endpackage

// File: rtl/sgcr_front.sv
// sgcr_front: accepts character beats, keeps the pen, looks up the glyph
// and pushes draw commands. Depends on sgcr_pkg.
module sgcr_front #(
  parameter int MAX_SCALE = sgcr_pkg::MAX_SCALE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sgcr_pkg::CODE_W-1:0]  char_code,
  input  logic                         new_string,
  input  logic [sgcr_pkg::COORD_W-1:0] start_x,
  input  logic [sgcr_pkg::COORD_W-1:0] start_y,
  input  logic [sgcr_pkg::SCALE_W-1:0] scale,
  input  logic [sgcr_pkg::COLOR_W-1:0] color,
  input  logic                         q_full,
  output logic                         q_push,
  output sgcr_pkg::cmd_t               q_cmd
);

  localparam int ADV_W = sgcr_pkg::COORD_W + 1;

  logic [sgcr_pkg::COORD_W-1:0] pen_x_r, pen_x_nxt;
  logic [sgcr_pkg::COORD_W-1:0] pen_y_r, pen_y_nxt;
  logic [sgcr_pkg::COORD_W-1:0] px, py, px_adv;
  logic [sgcr_pkg::SCALE_W-1:0] s_eff;
  logic [ADV_W-1:0]             adv_sum;
  sgcr_pkg::glyph_t             glyph;
  logic                         acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;

  assign px    = new_string ? start_x : pen_x_r;
  assign py    = new_string ? start_y : pen_y_r;
  assign s_eff = (int'(scale) > MAX_SCALE) ? sgcr_pkg::SCALE_W'(MAX_SCALE) : scale;
  assign glyph = sgcr_pkg::scan_order(sgcr_pkg::font_rows(char_code));

  assign adv_sum = ADV_W'(px) + ADV_W'(s_eff) * ADV_W'(6);
  assign px_adv  = adv_sum[sgcr_pkg::COORD_W] ? '1 : adv_sum[sgcr_pkg::COORD_W-1:0];

  assign q_push      = acc && (scale != '0) && (glyph != '0);
  assign q_cmd.pen_x = px;
  assign q_cmd.pen_y = py;
  assign q_cmd.scale = s_eff;
  assign q_cmd.cells = glyph;
  assign q_cmd.color = color;

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (acc) begin
      pen_y_nxt = py;
      pen_x_nxt = (scale == '0) ? px : px_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

// File: rtl/sgcr_queue.sv
// sgcr_queue: small flop-based FIFO between the front and back ends.
// Depends on nothing.
module sgcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign nonempty = (count_r != '0);
  assign count    = count_r;
  assign rdata    = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/sgcr_back.sv
// sgcr_back: scans one glyph cell per cycle unless stalled, clips, computes
// word offsets and holds one cell back to mark the last. Depends on sgcr_pkg.
module sgcr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sgcr_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  sgcr_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output sgcr_pkg::res_t out_res,
  output logic           out_last
);

  localparam int CX_W   = sgcr_pkg::CX_W;
  localparam int PROD_W = sgcr_pkg::PROD_W;
  localparam int DIM_W  = sgcr_pkg::CELL_DIM_W;
  localparam int OFF_W  = sgcr_pkg::OFFSET_W;

  // scan stage
  logic                                 busy_r, busy_nxt;
  logic [sgcr_pkg::SLOT_W-1:0]          slot_r, slot_nxt;
  logic [sgcr_pkg::COL_W-1:0]           col_r, col_nxt;
  sgcr_pkg::glyph_t                     cells_r, cells_nxt;
  logic [CX_W-1:0]                      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [sgcr_pkg::COORD_W-1:0]         x0_r, x0_nxt;
  logic [sgcr_pkg::SCALE_W-1:0]         s_r, s_nxt;
  logic [sgcr_pkg::COLOR_W-1:0]         color_r, color_nxt;

  logic                                 adv, is_cell, is_end, inframe;
  logic [CX_W-1:0]                      wdiff, hdiff;
  logic [DIM_W-1:0]                     w_cl, h_cl;

  // clip stage
  logic                                 s1_emit_r, s1_end_r;
  logic [CX_W-1:0]                      s1_cx_r, s1_cy_r;
  logic [DIM_W-1:0]                     s1_w_r, s1_h_r;
  logic [sgcr_pkg::COLOR_W-1:0]         s1_color_r;

  // multiply stage
  logic                                 s2_emit_r, s2_end_r;
  logic [PROD_W-1:0]                    s2_prod_r;
  logic [CX_W-1:0]                      s2_cx_r;
  logic [DIM_W-1:0]                     s2_w_r, s2_h_r;
  logic [sgcr_pkg::COLOR_W-1:0]         s2_color_r;

  // hold-back and output
  sgcr_pkg::res_t                       s2_res;
  logic                                 pend_v_r, pend_v_nxt;
  sgcr_pkg::res_t                       pend_r, pend_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_last_r, out_last_nxt;
  sgcr_pkg::res_t                       out_r, out_nxt;

  assign adv     = !out_valid_r || out_ready;
  assign q_pop   = adv && !busy_r && q_valid;
  assign is_cell = busy_r && (slot_r < sgcr_pkg::SLOT_W'(sgcr_pkg::GLYPH_CELLS));
  assign is_end  = busy_r && (slot_r == sgcr_pkg::SLOT_W'(sgcr_pkg::GLYPH_CELLS));
  assign inframe = (cx_r < CX_W'(cfg.frame_width)) && (cy_r < CX_W'(cfg.frame_height));
  assign wdiff   = CX_W'(cfg.frame_width) - cx_r;
  assign hdiff   = CX_W'(cfg.frame_height) - cy_r;
  assign w_cl    = (wdiff > CX_W'(s_r)) ? DIM_W'(s_r) : wdiff[DIM_W-1:0];
  assign h_cl    = (hdiff > CX_W'(s_r)) ? DIM_W'(s_r) : hdiff[DIM_W-1:0];

  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    col_nxt   = col_r;
    cells_nxt = cells_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    x0_nxt    = x0_r;
    s_nxt     = s_r;
    color_nxt = color_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      slot_nxt  = '0;
      col_nxt   = '0;
      cells_nxt = q_cmd.cells;
      cx_nxt    = CX_W'(q_cmd.pen_x);
      cy_nxt    = CX_W'(q_cmd.pen_y);
      x0_nxt    = q_cmd.pen_x;
      s_nxt     = q_cmd.scale;
      color_nxt = q_cmd.color;
    end else if (busy_r && adv) begin
      slot_nxt  = slot_r + 1'b1;
      cells_nxt = cells_r >> 1;
      if (col_r == sgcr_pkg::COL_W'(sgcr_pkg::GLYPH_COLS-1)) begin
        col_nxt = '0;
        cx_nxt  = CX_W'(x0_r);
        cy_nxt  = cy_r + CX_W'(s_r);
      end else begin
        col_nxt = col_r + 1'b1;
        cx_nxt  = cx_r + CX_W'(s_r);
      end
      if (is_end) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign s2_res.offset = OFF_W'(s2_prod_r[PROD_W-1:2]) + OFF_W'(s2_cx_r);
  assign s2_res.width  = s2_w_r;
  assign s2_res.height = s2_h_r;
  assign s2_res.color  = s2_color_r;

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_last_nxt  = out_last_r;
    out_nxt       = out_r;
    if (adv) begin
      if (s2_emit_r) begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          out_nxt       = pend_r;
        end
        pend_v_nxt = 1'b1;
        pend_nxt   = s2_res;
      end else if (s2_end_r && pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_nxt       = pend_r;
        pend_v_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= '0;
      col_r       <= '0;
      s1_emit_r   <= 1'b0;
      s1_end_r    <= 1'b0;
      s2_emit_r   <= 1'b0;
      s2_end_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      col_r       <= col_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s1_emit_r <= is_cell && cells_r[0] && inframe;
        s1_end_r  <= is_end;
        s2_emit_r <= s1_emit_r;
        s2_end_r  <= s1_end_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x0_r       <= x0_nxt;
    s_r        <= s_nxt;
    color_r    <= color_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (adv) begin
      s1_cx_r    <= cx_r;
      s1_cy_r    <= cy_r;
      s1_w_r     <= w_cl;
      s1_h_r     <= h_cl;
      s1_color_r <= color_r;
      s2_prod_r  <= PROD_W'(s1_cy_r) * PROD_W'(cfg.pitch_bytes);
      s2_cx_r    <= s1_cx_r;
      s2_w_r     <= s1_w_r;
      s2_h_r     <= s1_h_r;
      s2_color_r <= s1_color_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/scaled_glyph_cell_renderer.sv
// scaled_glyph_cell_renderer: top level; config registers, front end, command
// queue and cell back end. Depends on sgcr_pkg, sgcr_front, sgcr_queue, sgcr_back.
//
//  channel  dir  signals                 beat carries
//  in_      in   tvalid/tready/tdata/tuser  one character to draw
//  out_     out  tvalid/tready/tdata/tlast  one clipped square
//  cfg_     in   we/addr/wdata             frame width, height, pitch
//
// The front takes one beat per cycle while the queue has room; blank glyphs
// and scale zero push no command; a blank glyph still advances the pen, scale zero does not.
// The back loads a drawn character, scans its 35 cells and an end slot, only then pops another.
// A square is held until the next emitted cell or the end slot shows whether it is
// the last one; it passes the clip, multiply, hold-back and output registers.
// rst_n is synchronous: pen, queue and pipeline control clear, config registers to 0.
// A stall on out_tready freezes the back; the front stalls only on a full queue.
module scaled_glyph_cell_renderer #(
  parameter int MAX_SCALE   = sgcr_pkg::MAX_SCALE_DEF,
  parameter int QUEUE_DEPTH = sgcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // char_code[7:0], start_x[23:8], start_y[39:24], scale[43:40], color[75:44]
  input  logic [79:0]                        in_tdata,
  // new_string[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // word_offset[31:0], cell_width[35:32], cell_height[39:36], cell_color[71:40]
  output logic [71:0]                        out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [sgcr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [sgcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CMD_W = $bits(sgcr_pkg::cmd_t);
  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  sgcr_pkg::cfg_t cfg_r, cfg_nxt;
  sgcr_pkg::cmd_t push_cmd, head_cmd;
  sgcr_pkg::res_t out_res;
  logic           q_push, q_pop, q_full, q_nonempty;
  logic [CNT_W-1:0] q_count;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        sgcr_pkg::CFG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_wdata[sgcr_pkg::COORD_W-1:0];
        sgcr_pkg::CFG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_wdata[sgcr_pkg::COORD_W-1:0];
        sgcr_pkg::CFG_PITCH_BYTES:  cfg_nxt.pitch_bytes  = cfg_wdata[sgcr_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sgcr_front #(
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .char_code  (in_tdata[7:0]),
    .new_string (in_tuser),
    .start_x    (in_tdata[23:8]),
    .start_y    (in_tdata[39:24]),
    .scale      (in_tdata[43:40]),
    .color      (in_tdata[75:44]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  sgcr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (push_cmd),
    .pop      (q_pop),
    .rdata    (head_cmd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  sgcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_nonempty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_res.color, out_res.height, out_res.width, out_res.offset};

  // a delivered square is never clipped to nothing
  a_cell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[35:32] != 4'd0) && (out_tdata[39:36] != 4'd0))
    else $error("square with zero width or height");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(q_count) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_tready && !q_full)
    else $error("command pushed into full queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
